// ----- hw/rtl/smdb_pkg.sv -----
// ----------------------------------------------------------------------------
// smdb_pkg
// Shared types and codes for the double-buffered SPI master.
// ----------------------------------------------------------------------------
package smdb_pkg;

    // Transfer and divider sizing
    localparam int DATA_BITS    = 8;
    localparam int DIVIDER_BITS = 16;
    localparam int COUNT_BITS   = $clog2(DATA_BITS + 1);

    typedef logic [DATA_BITS-1:0]    data_t;
    typedef logic [DIVIDER_BITS-1:0] div_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [7:0]              byte_t;

    // Action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Register map
    localparam logic [1:0] REG_RX     = 2'd0;
    localparam logic [1:0] REG_TX     = 2'd1;
    localparam logic [1:0] REG_STATUS = 2'd2;
    localparam logic [1:0] REG_CTRL   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_POLARITY    = 2'd1;
    localparam logic [1:0] CFG_PHASE       = 2'd2;

    // Status and control bit positions
    localparam int STATUS_EMPTY_BIT  = 0;
    localparam int STATUS_READY_BIT  = 1;
    localparam int CTRL_PHASE_BIT    = 0;
    localparam int CTRL_POLARITY_BIT = 1;
    localparam int CTRL_SELECT_BIT   = 2;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] reg_index;
        byte_t      write_data;
        logic       miso_bit;
    } in_item_t;

    typedef struct packed {
        byte_t read_data;
        logic  sclk_level;
        logic  mosi_bit;
        logic  select_level;
        logic  write_dropped;
    } out_item_t;

endpackage

// ----- hw/rtl/spi_master_double_buffered.sv -----
// ----------------------------------------------------------------------------
// spi_master_double_buffered
// The result of an accepted transaction appears on out_data in the cycle after it is accepted.
// Throughput: one transaction per cycle; all state updates in a single pass.
// The result register frees itself as it is taken, so input stalls only
// while out_valid is high and out_ready is low.
// Reset: asynchronous, active low; select deasserted, shifter idle, empty.
// ----------------------------------------------------------------------------
module spi_master_double_buffered (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smdb_pkg::in_item_t   in_data,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output smdb_pkg::out_item_t  out_data
);

    // Configuration
    smdb_pkg::div_t   half_period_reg;
    logic             polarity_reg;
    logic             phase_reg;

    // Transfer state
    smdb_pkg::data_t  holding_reg,  holding_next;
    logic             hold_full_reg, hold_full_next;
    smdb_pkg::data_t  shift_reg,    shift_next;
    smdb_pkg::data_t  received_reg, received_next;
    smdb_pkg::count_t bits_left_reg, bits_left_next;
    logic             busy_reg,     busy_next;
    smdb_pkg::div_t   div_count_reg, div_count_next;
    logic             select_reg,   select_next;
    logic             past_lead_reg, past_lead_next;
    logic             sampled_reg,  sampled_next;

    // Result register
    logic                 out_valid_reg;
    smdb_pkg::out_item_t  out_item_reg;
    smdb_pkg::out_item_t  result;

    logic accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Work out the next state and the result for one transaction
    always_comb
    begin
        smdb_pkg::div_t   limit;
        smdb_pkg::div_t   div_inc;
        smdb_pkg::count_t bits_dec;
        logic             shift_in;

        holding_next   = holding_reg;
        hold_full_next = hold_full_reg;
        shift_next     = shift_reg;
        received_next  = received_reg;
        bits_left_next = bits_left_reg;
        busy_next      = busy_reg;
        div_count_next = div_count_reg;
        select_next    = select_reg;
        past_lead_next = past_lead_reg;
        sampled_next   = sampled_reg;

        result               = '0;
        limit                = (half_period_reg == '0) ? smdb_pkg::div_t'(1) : half_period_reg;
        div_inc              = div_count_reg + smdb_pkg::div_t'(1);
        bits_dec             = (bits_left_reg != '0) ? bits_left_reg - smdb_pkg::count_t'(1)
                                                     : bits_left_reg;
        shift_in             = phase_reg ? in_data.miso_bit : sampled_reg;

        case (in_data.action)
            smdb_pkg::ACT_TICK:
            begin
                if (!busy_reg)
                begin
                    // load a waiting byte into the idle shifter
                    if (hold_full_reg)
                    begin
                        shift_next     = holding_reg;
                        hold_full_next = 1'b0;
                        busy_next      = 1'b1;
                        bits_left_next = smdb_pkg::count_t'(smdb_pkg::DATA_BITS);
                        div_count_next = '0;
                        past_lead_next = 1'b0;
                    end
                end
                else if (div_inc >= limit || div_inc == '0)
                begin
                    // divider ran out: make one serial clock edge
                    div_count_next = '0;
                    if (!past_lead_reg)
                    begin
                        past_lead_next = 1'b1;
                        if (!phase_reg)
                        begin
                            sampled_next = in_data.miso_bit;
                        end
                    end
                    else
                    begin
                        past_lead_next = 1'b0;
                        shift_next     = {shift_reg[smdb_pkg::DATA_BITS-2:0], shift_in};
                        bits_left_next = bits_dec;
                        if (bits_dec == '0)
                        begin
                            received_next = {shift_reg[smdb_pkg::DATA_BITS-2:0], shift_in};
                            busy_next     = 1'b0;
                        end
                    end
                end
                else
                begin
                    div_count_next = div_inc;
                end
            end
            smdb_pkg::ACT_WRITE:
            begin
                if (in_data.reg_index == smdb_pkg::REG_TX)
                begin
                    // drop the write while the holding register is full
                    if (hold_full_reg)
                    begin
                        result.write_dropped = 1'b1;
                    end
                    else
                    begin
                        holding_next   = smdb_pkg::data_t'(in_data.write_data);
                        hold_full_next = 1'b1;
                    end
                end
                else if (in_data.reg_index == smdb_pkg::REG_CTRL)
                begin
                    select_next = in_data.write_data[smdb_pkg::CTRL_SELECT_BIT];
                end
            end
            smdb_pkg::ACT_READ:
            begin
                case (in_data.reg_index)
                    smdb_pkg::REG_RX:
                    begin
                        result.read_data = smdb_pkg::byte_t'(received_reg);
                    end
                    smdb_pkg::REG_TX:
                    begin
                        result.read_data = smdb_pkg::byte_t'(holding_reg);
                    end
                    smdb_pkg::REG_STATUS:
                    begin
                        result.read_data[smdb_pkg::STATUS_EMPTY_BIT] =
                            !busy_reg && !hold_full_reg;
                        result.read_data[smdb_pkg::STATUS_READY_BIT] = !hold_full_reg;
                    end
                    default:
                    begin
                        result.read_data[smdb_pkg::CTRL_SELECT_BIT]   = select_reg;
                        result.read_data[smdb_pkg::CTRL_POLARITY_BIT] = polarity_reg;
                        result.read_data[smdb_pkg::CTRL_PHASE_BIT]    = phase_reg;
                    end
                endcase
            end
            default:
            begin
                // unused action: no effect
            end
        endcase

        // Pins after the transaction
        result.sclk_level   = polarity_reg ^ past_lead_next;
        result.mosi_bit     = busy_next && shift_next[smdb_pkg::DATA_BITS-1];
        result.select_level = select_next;
    end

    // Hold configuration; the user must write it only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= smdb_pkg::div_t'(1);
            polarity_reg    <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                smdb_pkg::CFG_HALF_PERIOD: half_period_reg <= smdb_pkg::div_t'(cfg_data);
                smdb_pkg::CFG_POLARITY:    polarity_reg    <= cfg_data[0];
                smdb_pkg::CFG_PHASE:       phase_reg       <= cfg_data[0];
                default:
                begin
                    // no register at this index
                end
            endcase
        end
    end

    // Advance transfer state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg   <= '0;
            hold_full_reg <= 1'b0;
            shift_reg     <= '0;
            received_reg  <= '0;
            bits_left_reg <= '0;
            busy_reg      <= 1'b0;
            div_count_reg <= '0;
            select_reg    <= 1'b1;
            past_lead_reg <= 1'b0;
            sampled_reg   <= 1'b0;
        end
        else if (accept)
        begin
            holding_reg   <= holding_next;
            hold_full_reg <= hold_full_next;
            shift_reg     <= shift_next;
            received_reg  <= received_next;
            bits_left_reg <= bits_left_next;
            busy_reg      <= busy_next;
            div_count_reg <= div_count_next;
            select_reg    <= select_next;
            past_lead_reg <= past_lead_next;
            sampled_reg   <= sampled_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// ----- tb/spi_master_double_buffered_tb.sv -----
// ----------------------------------------------------------------------------
// spi_master_double_buffered_tb
// Self-checking bench for the double-buffered SPI master. Bus transactions
// (ticks, register writes, register reads) go in over a valid/ready channel.
// A transaction-level predictor of the serial engine and register map works out the
// response to each accepted transaction. Every response taken from the result
// channel is compared field by field against the oldest prediction. Both
// channels idle at random, with long receiver hold-offs. Clock modes and
// divider settings are changed between phases, including mid-transfer.
// ----------------------------------------------------------------------------
module spi_master_double_buffered_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT     = 500000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         TARGET_ITEMS    = 1200;
    localparam int         MAX_IDLE        = 18;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [1:0]           cfg_index;
    logic [15:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    smdb_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_ready;
    smdb_pkg::out_item_t  out_data;

    // Bench control
    int  errors      = 0;
    int  cycle_count = 0;
    int  sent_count  = 0;
    int  hold_req    = 0;
    bit  idle_on     = 1'b1;

    // Responses predicted but not yet seen, oldest first
    smdb_pkg::out_item_t pending_responses[$];

    // Predictor copy of configuration and state
    smdb_pkg::div_t   cfg_half;
    logic             cfg_pol;
    logic             cfg_pha;
    smdb_pkg::byte_t  tx_hold;
    logic             tx_full;
    smdb_pkg::data_t  shreg;
    smdb_pkg::data_t  rx_byte;
    smdb_pkg::count_t bits_rem;
    logic             busy;
    smdb_pkg::div_t   div_cnt;
    logic             sel;
    logic             lead_done;
    logic             lead_sample;

    spi_master_double_buffered u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // Generate the 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("spi_master_double_buffered verification failed");
            $finish;
        end
    end

    // Advance the predictor by one transaction and return the response
    function automatic smdb_pkg::out_item_t predict_bus_response(smdb_pkg::in_item_t it);
        smdb_pkg::out_item_t r;
        logic [16:0]         div_limit;
        logic [16:0]         div_next;
        logic                shift_in;
        r = '0;
        case (it.action)
            smdb_pkg::ACT_TICK:
            begin
                if (!busy)
                begin
                    // Load a waiting byte; no clock edge on this tick
                    if (tx_full)
                    begin
                        shreg     = smdb_pkg::data_t'(tx_hold);
                        tx_full   = 1'b0;
                        busy      = 1'b1;
                        bits_rem  = smdb_pkg::count_t'(smdb_pkg::DATA_BITS);
                        div_cnt   = '0;
                        lead_done = 1'b0;
                    end
                end
                else
                begin
                    // A zero half period behaves as one
                    div_limit = (cfg_half == '0) ? 17'd1 : {1'b0, cfg_half};
                    div_next  = {1'b0, div_cnt} + 17'd1;
                    if (div_next >= div_limit)
                    begin
                        div_cnt = '0;
                        if (!lead_done)
                        begin
                            lead_done = 1'b1;
                            if (!cfg_pha)
                                lead_sample = it.miso_bit;
                        end
                        else
                        begin
                            // Trailing edge: shift, and finish after the last bit
                            shift_in  = cfg_pha ? it.miso_bit : lead_sample;
                            lead_done = 1'b0;
                            shreg     = {shreg[smdb_pkg::DATA_BITS-2:0], shift_in};
                            if (bits_rem != '0)
                                bits_rem--;
                            if (bits_rem == '0)
                            begin
                                rx_byte = shreg;
                                busy    = 1'b0;
                            end
                        end
                    end
                    else
                        div_cnt = div_next[smdb_pkg::DIVIDER_BITS-1:0];
                end
            end
            smdb_pkg::ACT_WRITE:
            begin
                if (it.reg_index == smdb_pkg::REG_TX)
                begin
                    if (tx_full)
                        r.write_dropped = 1'b1;
                    else
                    begin
                        tx_hold = it.write_data;
                        tx_full = 1'b1;
                    end
                end
                else if (it.reg_index == smdb_pkg::REG_CTRL)
                    sel = it.write_data[smdb_pkg::CTRL_SELECT_BIT];
            end
            smdb_pkg::ACT_READ:
            begin
                case (it.reg_index)
                    smdb_pkg::REG_RX:     r.read_data = smdb_pkg::byte_t'(rx_byte);
                    smdb_pkg::REG_TX:     r.read_data = tx_hold;
                    smdb_pkg::REG_STATUS:
                    begin
                        r.read_data[smdb_pkg::STATUS_EMPTY_BIT] = !busy && !tx_full;
                        r.read_data[smdb_pkg::STATUS_READY_BIT] = !tx_full;
                    end
                    default:
                    begin
                        r.read_data[smdb_pkg::CTRL_SELECT_BIT]   = sel;
                        r.read_data[smdb_pkg::CTRL_POLARITY_BIT] = cfg_pol;
                        r.read_data[smdb_pkg::CTRL_PHASE_BIT]    = cfg_pha;
                    end
                endcase
            end
            default: ;
        endcase
        r.sclk_level   = cfg_pol ^ lead_done;
        r.mosi_bit     = busy ? shreg[smdb_pkg::DATA_BITS-1] : 1'b0;
        r.select_level = sel;
        return r;
    endfunction

    function automatic smdb_pkg::in_item_t make_item(logic [1:0] act, logic [1:0] idx,
                                                     smdb_pkg::byte_t wdata, logic miso);
        smdb_pkg::in_item_t it;
        it.action     = act;
        it.reg_index  = idx;
        it.write_data = wdata;
        it.miso_bit   = miso;
        return it;
    endfunction

    // Mostly ticks and transmit writes so transfers run through, plus noise
    function automatic smdb_pkg::in_item_t random_item();
        smdb_pkg::in_item_t it;
        int                 pick;
        it.action     = smdb_pkg::ACT_TICK;
        it.reg_index  = 2'($urandom);
        it.write_data = 8'($urandom);
        it.miso_bit   = 1'($urandom);
        pick          = $urandom_range(0, 99);
        if (pick >= 96)
            it.action = ACT_UNUSED;
        else if (pick >= 92)
        begin
            it.action    = smdb_pkg::ACT_WRITE;
            it.reg_index = ($urandom_range(0, 1) == 0) ? smdb_pkg::REG_RX
                                                       : smdb_pkg::REG_STATUS;
        end
        else if (pick >= 86)
        begin
            it.action    = smdb_pkg::ACT_WRITE;
            it.reg_index = smdb_pkg::REG_CTRL;
        end
        else if (pick >= 74)
            it.action = smdb_pkg::ACT_READ;
        else if (pick >= 62)
        begin
            it.action    = smdb_pkg::ACT_WRITE;
            it.reg_index = smdb_pkg::REG_TX;
        end
        return it;
    endfunction

    // Offer one transaction and record its predicted response on acceptance
    task automatic send_item(smdb_pkg::in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pending_responses.push_back(predict_bus_response(it));
        sent_count++;
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_item(make_item(smdb_pkg::ACT_TICK, 2'($urandom), 8'($urandom),
                                1'($urandom)));
    endtask

    task automatic send_random(int n);
        repeat (n) send_item(random_item());
    endtask

    // Drop valid and wait for every outstanding response
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write one configuration register; some callers do so mid-transfer
    task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            smdb_pkg::CFG_HALF_PERIOD: cfg_half = value;
            smdb_pkg::CFG_POLARITY:    cfg_pol  = value[0];
            smdb_pkg::CFG_PHASE:       cfg_pha  = value[0];
            default: ;
        endcase
    endtask

    // Set all three registers, with junk in the unused upper bits
    task automatic apply_mode(smdb_pkg::div_t half, logic pol, logic pha);
        logic [14:0] junk;
        cfg_write(smdb_pkg::CFG_HALF_PERIOD, half);
        junk = 15'($urandom);
        cfg_write(smdb_pkg::CFG_POLARITY, {junk, pol});
        junk = 15'($urandom);
        cfg_write(smdb_pkg::CFG_PHASE, {junk, pha});
    endtask

    task automatic report_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Check each response transaction against the oldest prediction
    always @(posedge clk)
    begin : check_responses
        smdb_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response, expected none actual %0h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                report_field("read_data", int'(want.read_data),
                             int'(out_data.read_data));
                report_field("sclk_level", int'(want.sclk_level),
                             int'(out_data.sclk_level));
                report_field("mosi_bit", int'(want.mosi_bit),
                             int'(out_data.mosi_bit));
                report_field("select_level", int'(want.select_level),
                             int'(out_data.select_level));
                report_field("write_dropped", int'(want.write_dropped),
                             int'(out_data.write_dropped));
            end
        end
    end

    // Receiver: random stalls per response, plus requested long hold-offs
    initial
    begin
        int stall_cycles;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall_cycles = hold_req + (idle_on ? $urandom_range(0, MAX_IDLE) : 0);
            hold_req     = 0;
            if (stall_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Register map after reset, ignored writes, unused action, control
    task automatic test_register_map();
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_RX, 8'h00, 1'b0));
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_TX, 8'hFF, 1'b1));
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_STATUS, 8'h00, 1'b0));
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_CTRL, 8'h00, 1'b0));
        send_item(make_item(smdb_pkg::ACT_TICK, smdb_pkg::REG_RX, 8'h00, 1'b1));
        send_item(make_item(ACT_UNUSED, smdb_pkg::REG_TX, 8'hFF, 1'b1));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_RX, 8'hFF, 1'b0));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_STATUS, 8'hFF, 1'b0));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_CTRL, 8'hFB, 1'b0));
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_CTRL, 8'h00, 1'b0));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_CTRL, 8'h04, 1'b0));
        drain_results();
    endtask

    // One full transfer at a zero half period, with a dropped write
    task automatic test_first_transfer();
        apply_mode(16'h0000, 1'b0, 1'b0);
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_TX, 8'hFF, 1'b0));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_TX, 8'h00, 1'b1));
        send_item(make_item(smdb_pkg::ACT_TICK, smdb_pkg::REG_TX, 8'h00, 1'b1));
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_TX, 8'h00, 1'b0));
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_STATUS, 8'h00, 1'b0));
        send_ticks(16);
        send_item(make_item(smdb_pkg::ACT_READ, smdb_pkg::REG_RX, 8'h00, 1'b0));
        drain_results();
    endtask

    // Every clock mode at several divider settings
    task automatic test_clock_modes();
        for (int m = 0; m < 8; m++)
        begin
            idle_on = (m != 5);
            apply_mode((m < 4) ? smdb_pkg::div_t'(m)
                               : smdb_pkg::div_t'($urandom_range(1, 4)),
                       m[0], m[1]);
            send_random(60);
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    // Flip polarity and then phase while a transfer is in progress
    task automatic test_mid_transfer_config();
        repeat (4)
        begin
            apply_mode(smdb_pkg::div_t'($urandom_range(1, 3)), 1'($urandom), 1'($urandom));
            send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_TX, 8'($urandom),
                                1'($urandom)));
            send_ticks($urandom_range(3, 20));
            drain_results();
            cfg_write(smdb_pkg::CFG_POLARITY, {15'($urandom), ~cfg_pol});
            send_ticks($urandom_range(5, 15));
            drain_results();
            cfg_write(smdb_pkg::CFG_PHASE, {15'($urandom), ~cfg_pha});
            send_ticks($urandom_range(10, 30));
            drain_results();
        end
    endtask

    // Largest divider, then random and small ones cutting the count short
    task automatic test_slow_divider();
        apply_mode(16'hFFFF, 1'b1, 1'b0);
        send_item(make_item(smdb_pkg::ACT_WRITE, smdb_pkg::REG_TX, 8'($urandom), 1'b0));
        send_ticks(60);
        drain_results();
        cfg_write(smdb_pkg::CFG_HALF_PERIOD, 16'($urandom));
        send_ticks(20);
        drain_results();
        cfg_write(smdb_pkg::CFG_HALF_PERIOD, 16'd3);
        send_ticks(40);
        drain_results();
    endtask

    // Hold the receiver off while the sender keeps offering transactions
    task automatic test_backpressure();
        apply_mode(16'd1, 1'($urandom), 1'($urandom));
        idle_on  = 1'b0;
        hold_req = HOLD_OFF_CYCLES;
        send_random(60);
        drain_results();
        idle_on = 1'b1;
    endtask

    // Random phases with a fresh configuration each time
    task automatic test_random_soak();
        smdb_pkg::div_t half;
        while (sent_count < TARGET_ITEMS)
        begin
            half = ($urandom_range(0, 7) == 0) ? smdb_pkg::div_t'($urandom_range(5, 12))
                                               : smdb_pkg::div_t'($urandom_range(0, 4));
            apply_mode(half, 1'($urandom), 1'($urandom));
            idle_on = ($urandom_range(0, 3) != 0);
            send_random(50);
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        // Predictor reset state
        cfg_half    = 16'd1;
        cfg_pol     = 1'b0;
        cfg_pha     = 1'b0;
        tx_hold     = '0;
        tx_full     = 1'b0;
        shreg       = '0;
        rx_byte     = '0;
        bits_rem    = '0;
        busy        = 1'b0;
        div_cnt     = '0;
        sel         = 1'b1;
        lead_done   = 1'b0;
        lead_sample = 1'b0;

        // Drive inputs known and hold reset
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_map();
        test_first_transfer();
        test_clock_modes();
        test_mid_transfer_config();
        test_slow_divider();
        test_backpressure();
        test_random_soak();

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("spi_master_double_buffered verification clean");
        else
            $display("spi_master_double_buffered verification failed");
        $finish;
    end

endmodule
